/* src/fixed_block_pool_allocator_macros.svh */
// Assertion macros used by the pool allocator core.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FBPA_ASSERT(lbl, prop, msg)
`define FBPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/fbpa_pkg.sv */
// Types and fixed constants of the fixed block pool allocator.
package fbpa_pkg;

	localparam int ADDR_W   = 13;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OOM      = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_t;

	typedef enum logic {
		FSM_RUN  = 1'b0,
		FSM_LINK = 1'b1
	} fsm_t;

	// Request held in the input register, with the free address already split.
	typedef struct packed {
		logic              valid;
		req_t              kind;
		logic [ADDR_W-1:0] gblk;
		logic [ADDR_W-1:0] frame;
	} s1_req_t;

endpackage

/* src/fbpa_ram.sv */
// Generic single write port RAM with one registered read port.
module fbpa_ram import fbpa_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/fbpa_ingress.sv */
// Input register; splits a free address into frame and global block index.
module fbpa_ingress import fbpa_pkg::*; #(
	parameter int BLOCKS_PER_FRAME = 64,
	parameter int BLOCK_BYTES      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] free_address,
	input  logic              take,
	output s1_req_t           s1
);

	localparam longint unsigned FRAME_BYTES =
		longint'(BLOCKS_PER_FRAME) * longint'(BLOCK_BYTES);
	localparam int BB_S   = ADDR_W + $clog2(BLOCK_BYTES);
	localparam int FB_S   = ADDR_W + $clog2(FRAME_BYTES);
	localparam int MUL_W  = ADDR_W + 2;
	localparam int PROD_W = ADDR_W + MUL_W;
	// Reciprocals rounded up; exact floor for every 13-bit dividend.
	localparam logic [MUL_W-1:0] BB_MUL =
		MUL_W'((64'd1 << BB_S) / BLOCK_BYTES + 1);
	localparam logic [MUL_W-1:0] FB_MUL =
		MUL_W'((64'd1 << FB_S) / FRAME_BYTES + 1);

	logic              valid_s1;
	req_t              kind_s1;
	logic [ADDR_W-1:0] gblk_s1;
	logic [ADDR_W-1:0] frame_s1;
	logic [PROD_W-1:0] gblk_prod;
	logic [PROD_W-1:0] frame_prod;
	logic              accept;

	assign req_ready  = !valid_s1 || take;
	assign accept     = req_valid && req_ready;
	assign gblk_prod  = PROD_W'(free_address) * PROD_W'(BB_MUL);
	assign frame_prod = PROD_W'(free_address) * PROD_W'(FB_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req_t'(req_type);
			gblk_s1  <= ADDR_W'(gblk_prod >> BB_S);
			frame_s1 <= ADDR_W'(frame_prod >> FB_S);
		end
	end

	assign s1.valid = valid_s1;
	assign s1.kind  = kind_s1;
	assign s1.gblk  = gblk_s1;
	assign s1.frame = frame_s1;

endmodule

/* src/fbpa_core.sv */
// Frame state, allocation and free logic, link memory and result register.
`include "fixed_block_pool_allocator_macros.svh"
module fbpa_core import fbpa_pkg::*; #(
	parameter int BLOCKS_PER_FRAME = 64,
	parameter int MAX_FRAMES       = 8,
	parameter int BLOCK_BYTES      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  s1_req_t             s1,
	output logic                take,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [ADDR_W-1:0]   block_address
);

	localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int BW   = $clog2(BLOCKS_PER_FRAME);
	localparam int HW   = $clog2(BLOCKS_PER_FRAME + 1);
	localparam int FA_W = $clog2(MAX_FRAMES + 1);
	localparam logic [HW-1:0]     NO_BLOCK = HW'(BLOCKS_PER_FRAME);
	localparam logic [ADDR_W-1:0] BPF_C    = ADDR_W'(BLOCKS_PER_FRAME);
	localparam logic [ADDR_W-1:0] BB_C     = ADDR_W'(BLOCK_BYTES);
	localparam logic [ADDR_W-1:0] FB_C     =
		ADDR_W'(longint'(BLOCKS_PER_FRAME) * longint'(BLOCK_BYTES));

	fsm_t              state_q, state_d;
	logic [HW-1:0]     head_q  [MAX_FRAMES];
	logic [HW-1:0]     fresh_q [MAX_FRAMES];
	logic [FA_W-1:0]   frames_active_q;
	logic [FW-1:0]     link_f_q;
	logic [BW-1:0]     link_b_q;
	logic              rsp_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] addr_q;

	logic [MAX_FRAMES-1:0] avail;
	logic                  pick_found;
	logic [FW-1:0]         pick_f;
	logic [FW-1:0]         free_f;
	logic [ADDR_W-1:0]     free_off;
	logic [BW-1:0]         free_b;
	logic                  free_ok;
	logic [HW-1:0]         rd_data;

	logic              pop_link, pop_fresh, activate, do_free, do_clear;
	logic              res_load, res_has_addr;
	status_t           res_status;
	logic [FW-1:0]     addr_f;
	logic [BW-1:0]     addr_b;
	logic [ADDR_W-1:0] res_addr;

	assign take = (state_q == FSM_RUN) && s1.valid && (!rsp_valid_q || rsp_ready);

	// Lowest active frame that still has a free block.
	always_comb begin
		pick_found = 1'b0;
		pick_f     = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			avail[i] = (FA_W'(i) < frames_active_q) &&
				((head_q[i] < NO_BLOCK) || (fresh_q[i] < NO_BLOCK));
			if (avail[i] && !pick_found) begin
				pick_found = 1'b1;
				pick_f     = FW'(i);
			end
		end
	end

	assign free_f   = s1.frame[FW-1:0];
	assign free_off = s1.gblk - s1.frame * BPF_C;
	assign free_b   = free_off[BW-1:0];
	assign free_ok  = s1.frame < ADDR_W'(frames_active_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_RUN: begin
				if (pop_link) begin
					state_d = FSM_LINK;
				end
			end
			FSM_LINK: state_d = FSM_RUN;
			default:  state_d = FSM_RUN;
		endcase
	end

	always_comb begin
		pop_link     = 1'b0;
		pop_fresh    = 1'b0;
		activate     = 1'b0;
		do_free      = 1'b0;
		do_clear     = 1'b0;
		res_load     = 1'b0;
		res_has_addr = 1'b0;
		res_status   = ST_OK;
		addr_f       = link_f_q;
		addr_b       = link_b_q;
		if (state_q == FSM_LINK) begin
			res_load     = 1'b1;
			res_has_addr = 1'b1;
		end else if (take) begin
			case (s1.kind)
				REQ_ALLOC: begin
					if (pick_found) begin
						addr_f = pick_f;
						if (head_q[pick_f] < NO_BLOCK) begin
							// The next link comes from memory in the following cycle.
							pop_link = 1'b1;
							addr_b   = head_q[pick_f][BW-1:0];
						end else begin
							pop_fresh    = 1'b1;
							res_load     = 1'b1;
							res_has_addr = 1'b1;
							addr_b       = fresh_q[pick_f][BW-1:0];
						end
					end else if (frames_active_q < FA_W'(MAX_FRAMES)) begin
						activate     = 1'b1;
						res_load     = 1'b1;
						res_has_addr = 1'b1;
						addr_f       = frames_active_q[FW-1:0];
						addr_b       = '0;
					end else begin
						res_load   = 1'b1;
						res_status = ST_OOM;
					end
				end
				REQ_FREE: begin
					res_load = 1'b1;
					if (free_ok) begin
						do_free = 1'b1;
					end else begin
						res_status = ST_BAD_ADDR;
					end
				end
				REQ_CLEAR: begin
					res_load = 1'b1;
					do_clear = 1'b1;
				end
				default: res_load = 1'b1;
			endcase
		end
	end

	assign res_addr = ADDR_W'(addr_f) * FB_C + ADDR_W'(addr_b) * BB_C;

	fbpa_ram #(
		.WIDTH(HW),
		.DEPTH(2 ** (FW + BW))
	) u_link_ram (
		.clk  (clk),
		.we   (do_free),
		.waddr({free_f, free_b}),
		.wdata(head_q[free_f]),
		.raddr({pick_f, head_q[pick_f][BW-1:0]}),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= FSM_RUN;
			frames_active_q <= FA_W'(1);
			rsp_valid_q     <= 1'b0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				head_q[i]  <= NO_BLOCK;
				fresh_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == FSM_LINK) begin
				head_q[link_f_q] <= rd_data;
			end
			if (pop_fresh) begin
				fresh_q[pick_f] <= fresh_q[pick_f] + HW'(1);
			end
			if (activate) begin
				head_q[addr_f]  <= NO_BLOCK;
				fresh_q[addr_f] <= HW'(1);
				frames_active_q <= frames_active_q + FA_W'(1);
			end
			if (do_free) begin
				head_q[free_f] <= HW'(free_b);
			end
			if (do_clear) begin
				frames_active_q <= FA_W'(1);
				head_q[0]       <= NO_BLOCK;
				fresh_q[0]      <= '0;
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_link) begin
			link_f_q <= addr_f;
			link_b_q <= addr_b;
		end
		if (res_load) begin
			status_q <= res_status;
			addr_q   <= res_has_addr ? res_addr : '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;

	`FBPA_ASSERT(a_link_out_empty, state_q == FSM_LINK |-> !rsp_valid_q, "Result pending during link read")
	`FBPA_ASSERT_NEXT(a_link_enter, pop_link, state_q == FSM_LINK, "Linked pop did not wait for memory")
	`FBPA_ASSERT_NEXT(a_link_leave, state_q == FSM_LINK, state_q == FSM_RUN && rsp_valid_q, "Link wait did not finish")
	`FBPA_ASSERT_NEXT(a_direct_answer, take && !pop_link, rsp_valid_q, "Request gave no result")
	`FBPA_ASSERT(a_frames_range, frames_active_q != '0 && frames_active_q <= FA_W'(MAX_FRAMES), "Active frame count out of range")

endmodule

/* src/fixed_block_pool_allocator.sv */
// A word is held in the input register, then its result is registered in the result register.
// An alloc that pops a freed block also waits for the link memory read.
// One word per cycle while results are taken; during a link memory read the next word waits in the input register.
// Reset is asynchronous: frame 0 comes up active and fresh and both registers empty.
// The link memory is not cleared; each entry is written by a free before it is read.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
	parameter int BLOCKS_PER_FRAME = 64,
	parameter int MAX_FRAMES       = 8,
	parameter int BLOCK_BYTES      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [ADDR_W-1:0]   free_address,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [STATUS_W-1:0] status,
	output logic [ADDR_W-1:0]   block_address
);

	s1_req_t s1;
	logic    take;

	fbpa_ingress #(
		.BLOCKS_PER_FRAME(BLOCKS_PER_FRAME),
		.BLOCK_BYTES     (BLOCK_BYTES)
	) u_ingress (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.free_address(free_address),
		.take        (take),
		.s1          (s1)
	);

	fbpa_core #(
		.BLOCKS_PER_FRAME(BLOCKS_PER_FRAME),
		.MAX_FRAMES      (MAX_FRAMES),
		.BLOCK_BYTES     (BLOCK_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1           (s1),
		.take         (take),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.block_address(block_address)
	);

endmodule
